[sv/qss_pkg.sv]
// qss_pkg: types, character codes and the escape decode function
// shared by the quoted-string scanner modules; no dependencies
`default_nettype none

package qss_pkg;

  // scan mode held in the configuration register
  typedef enum logic {
    MODE_EXTRACT = 1'b0,
    MODE_EXCLUDE = 1'b1
  } mode_e;

  // which quote opened the current string
  typedef enum logic [1:0] {
    QK_OUT    = 2'd0,
    QK_SINGLE = 2'd1,
    QK_DOUBLE = 2'd2
  } quote_kind_e;

  // character codes
  localparam logic [7:0] CHAR_DQ = 8'h22;
  localparam logic [7:0] CHAR_SQ = 8'h27;
  localparam logic [7:0] CHAR_BS = 8'h5C;

  // escape letters and the control codes they stand for
  localparam logic [7:0] ESC_N = 8'h6E;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_V = 8'h76;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_HT = 8'h09;
  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_VT = 8'h0B;

  // one input request
  typedef struct packed {
    logic [7:0] char_in;
    logic       line_last;
  } in_t;

  // one result request
  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       string_end;
    logic       open_dropped;
    logic       line_end;
  } out_t;

  // map an escaped letter to its control code, others pass through
  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ESC_N:   r = CODE_LF;
      ESC_T:   r = CODE_HT;
      ESC_B:   r = CODE_BS;
      ESC_R:   r = CODE_CR;
      ESC_F:   r = CODE_FF;
      ESC_V:   r = CODE_VT;
      default: r = c;
    endcase
    return r;
  endfunction

  // quote kind that a byte would open or close
  function automatic quote_kind_e quote_of(input logic [7:0] c);
    quote_kind_e r;
    case (c)
      CHAR_DQ: r = QK_DOUBLE;
      CHAR_SQ: r = QK_SINGLE;
      default: r = QK_OUT;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/qss_scan.sv]
// qss_scan: per-byte scan logic and the quote/escape state registers
// depends on qss_pkg
`default_nettype none

module qss_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qss_pkg::mode_e  mode_i,
  input  wire qss_pkg::in_t    item_i,
  input  wire logic            step_i,
  output logic                 has_result_o,
  output qss_pkg::out_t        result_o
);

  qss_pkg::quote_kind_e kind_q, kind_d;
  logic                 esc_q, esc_d;

  qss_pkg::quote_kind_e qc;
  logic [7:0]           ch;
  logic                 send, closed, dropped, last;

  // next state and result for the byte in the input register
  always_comb begin
    qc      = qss_pkg::quote_of(item_i.char_in);
    ch      = item_i.char_in;
    last    = item_i.line_last;
    send    = 1'b0;
    closed  = 1'b0;
    dropped = 1'b0;
    kind_d  = kind_q;
    esc_d   = esc_q;

    case (mode_i)
      qss_pkg::MODE_EXTRACT: begin
        if (esc_q) begin
          send  = 1'b1;
          ch    = qss_pkg::decode_escape(item_i.char_in);
          esc_d = 1'b0;
        end else if (qc != qss_pkg::QK_OUT) begin
          send = 1'b1;
          if (kind_q == qss_pkg::QK_OUT) begin
            kind_d = qc;
          end else if (kind_q == qc) begin
            kind_d = qss_pkg::QK_OUT;
            closed = 1'b1;
          end
        end else if (kind_q != qss_pkg::QK_OUT) begin
          if (item_i.char_in == qss_pkg::CHAR_BS) begin
            esc_d = 1'b1;
          end else begin
            send = 1'b1;
          end
        end
        dropped = last && (kind_d != qss_pkg::QK_OUT);
      end
      default: begin
        if (qc != qss_pkg::QK_OUT && !esc_q) begin
          if (kind_q == qss_pkg::QK_OUT) begin
            kind_d = qc;
            send   = 1'b1;
          end else if (kind_q == qc) begin
            kind_d = qss_pkg::QK_OUT;
            send   = 1'b1;
          end
        end else if (kind_q == qss_pkg::QK_OUT) begin
          send = 1'b1;
        end
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (item_i.char_in == qss_pkg::CHAR_BS && kind_d != qss_pkg::QK_OUT) begin
          esc_d = 1'b1;
        end
      end
    endcase

    // line end returns the scan to its reset state
    if (last) begin
      kind_d = qss_pkg::QK_OUT;
      esc_d  = 1'b0;
    end

    has_result_o          = send || last;
    result_o.char_out     = send ? ch : 8'h00;
    result_o.char_valid   = send;
    result_o.string_end   = closed;
    result_o.open_dropped = dropped;
    result_o.line_end     = last;
  end

  // state advances once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= qss_pkg::QK_OUT;
      esc_q  <= 1'b0;
    end else if (step_i) begin
      kind_q <= kind_d;
      esc_q  <= esc_d;
    end
  end

endmodule

`default_nettype wire

[sv/quoted_string_scanner.sv]
// quoted_string_scanner: top level with input register, scan step and result register
// depends on qss_pkg and qss_scan
`default_nettype none

// Scans a text line one byte per request and passes on either the quoted
// strings (extract mode, escapes decoded, string_end on the closing quote,
// open_dropped when the line ends inside a string) or the text outside them
// (exclude mode). A byte that emits nothing and is not the line's last gives
// no result. Throughput is one byte per clock when the result side does not
// stall. Each accepted byte sits in the input register; when it steps, the
// single quote/escape state update runs and its result, if any, loads the
// result register. The user must write the mode register through
// cfg_we_i/cfg_data_i only while the block is idle; the block does not enforce this.
module quoted_string_scanner (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire qss_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output qss_pkg::out_t      out_data_o
);

  qss_pkg::mode_e mode_q;
  logic           s1_valid_q;
  qss_pkg::in_t   s1_data_q;
  logic           out_valid_q;
  qss_pkg::out_t  out_data_q;

  logic           has_result;
  qss_pkg::out_t  result;
  logic           out_free, s1_step;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qss_pkg::MODE_EXTRACT;
    end else if (cfg_we_i) begin
      mode_q <= qss_pkg::mode_e'(cfg_data_i);
    end
  end

  // handshake between the two register stages
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_step    = s1_valid_q && (!has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // scan step
  qss_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .item_i       (s1_data_q),
    .step_i       (s1_step),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_step && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step && has_result) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench: self-checking bench for quoted_string_scanner, directed table then random lines
// depends on qss_pkg and the quoted_string_scanner RTL
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qss_pkg::*;

  localparam int N_DIR        = 25;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 155;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 80;

  // one row of the directed table; res is used only where typed is set
  typedef struct packed {
    mode_e      md;
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    out_t       res;
  } row_t;

  localparam row_t DIR_ROWS [N_DIR] = '{
    // extract mode: escapes, the other quote, byte extremes, close
    '{MODE_EXTRACT, 8'h61,   1'b0, 1'b0, '0},
    '{MODE_EXTRACT, CHAR_DQ, 1'b0, 1'b1, '{CHAR_DQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, CHAR_BS, 1'b0, 1'b0, '0},
    '{MODE_EXTRACT, ESC_N,   1'b0, 1'b1, '{CODE_LF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, CHAR_BS, 1'b0, 1'b0, '0},
    '{MODE_EXTRACT, ESC_V,   1'b0, 1'b1, '{CODE_VT, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, CHAR_BS, 1'b0, 1'b0, '0},
    '{MODE_EXTRACT, CHAR_DQ, 1'b0, 1'b1, '{CHAR_DQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, CHAR_SQ, 1'b0, 1'b1, '{CHAR_SQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, 8'h00,   1'b0, 1'b1, '{8'h00,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, 8'hFF,   1'b0, 1'b1, '{8'hFF,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, CHAR_DQ, 1'b0, 1'b1, '{CHAR_DQ, 1'b1, 1'b1, 1'b0, 1'b0}},
    // backslash outside a string is plain text, line ends with nothing to emit
    '{MODE_EXTRACT, CHAR_BS, 1'b0, 1'b0, '0},
    '{MODE_EXTRACT, 8'hFF,   1'b1, 1'b1, '{8'h00,   1'b0, 1'b0, 1'b0, 1'b1}},
    '{MODE_EXTRACT, CHAR_SQ, 1'b0, 1'b1, '{CHAR_SQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXTRACT, 8'h71,   1'b0, 1'b0, '0},
    // switch to exclude mode inside the single-quoted string
    '{MODE_EXCLUDE, 8'h7A,   1'b0, 1'b0, '0},
    '{MODE_EXCLUDE, CHAR_DQ, 1'b0, 1'b0, '0},
    '{MODE_EXCLUDE, CHAR_BS, 1'b0, 1'b0, '0},
    '{MODE_EXCLUDE, CHAR_SQ, 1'b0, 1'b0, '0},
    '{MODE_EXCLUDE, CHAR_SQ, 1'b0, 1'b1, '{CHAR_SQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXCLUDE, CHAR_BS, 1'b0, 1'b1, '{CHAR_BS, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{MODE_EXCLUDE, CHAR_DQ, 1'b0, 1'b1, '{CHAR_DQ, 1'b1, 1'b0, 1'b0, 1'b0}},
    // back to extract inside the string, line ends open
    '{MODE_EXTRACT, 8'h6B,   1'b1, 1'b1, '{8'h6B,   1'b1, 1'b0, 1'b1, 1'b1}},
    '{MODE_EXCLUDE, 8'h00,   1'b1, 1'b1, '{8'h00,   1'b1, 1'b0, 1'b0, 1'b1}}
  };

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  logic  cfg_data_i  = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  in_ready_o;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  // scanner state as the bench sees it
  mode_e       cur_mode  = MODE_EXTRACT;
  quote_kind_e cur_quote = QK_OUT;
  bit          esc_open  = 1'b0;

  out_t due_results [$];
  int   bad_count = 0;
  bit   no_idle   = 1'b0;
  bit   hold_req  = 1'b0;

  quoted_string_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the scan state by one byte; returns 1 if the byte yields a result
  function automatic bit scan_byte(input logic [7:0] c, input logic lst, output out_t res);
    quote_kind_e q;
    logic [7:0]  o;
    bit          send;
    bit          closed;
    bit          dropped;
    q       = (c == CHAR_DQ) ? QK_DOUBLE : (c == CHAR_SQ) ? QK_SINGLE : QK_OUT;
    o       = c;
    send    = 1'b0;
    closed  = 1'b0;
    dropped = 1'b0;
    if (cur_mode == MODE_EXTRACT) begin
      if (esc_open) begin
        // escaped byte: letters map to control codes, all else passes
        send = 1'b1;
        unique case (c)
          ESC_N:   o = CODE_LF;
          ESC_T:   o = CODE_HT;
          ESC_B:   o = CODE_BS;
          ESC_R:   o = CODE_CR;
          ESC_F:   o = CODE_FF;
          ESC_V:   o = CODE_VT;
          default: o = c;
        endcase
        esc_open = 1'b0;
      end else if (q != QK_OUT) begin
        send = 1'b1;
        if (cur_quote == QK_OUT) begin
          cur_quote = q;
        end else if (cur_quote == q) begin
          cur_quote = QK_OUT;
          closed    = 1'b1;
        end
      end else if (cur_quote != QK_OUT) begin
        if (c == CHAR_BS) esc_open = 1'b1;
        else send = 1'b1;
      end
      dropped = lst && (cur_quote != QK_OUT);
    end else begin
      // exclude: outside text and the delimiting quotes only
      if (q != QK_OUT && !esc_open) begin
        if (cur_quote == QK_OUT) begin
          cur_quote = q;
          send      = 1'b1;
        end else if (cur_quote == q) begin
          cur_quote = QK_OUT;
          send      = 1'b1;
        end
      end else if (cur_quote == QK_OUT) begin
        send = 1'b1;
      end
      if (esc_open) esc_open = 1'b0;
      else if (c == CHAR_BS && cur_quote != QK_OUT) esc_open = 1'b1;
    end
    res.char_out     = send ? o : 8'h00;
    res.char_valid   = send;
    res.string_end   = closed;
    res.open_dropped = dropped;
    res.line_end     = lst;
    if (lst) begin
      cur_quote = QK_OUT;
      esc_open  = 1'b0;
    end
    return send || lst;
  endfunction

  // offer one byte, wait for its acceptance, then queue what it should yield
  task automatic offer_byte(input logic [7:0] c, input logic lst, input logic typed,
                            input out_t typed_res);
    out_t res;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{char_in: c, line_last: lst};
    do @(posedge clk_i); while (!in_ready_o);
    if (scan_byte(c, lst, res)) begin
      if (typed) res = typed_res;
      due_results = {due_results, res};
    end
  endtask

  // stop sending and let every pending result and any silent byte drain out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input mode_e m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cur_mode = m;
    cfg_we_i <= 1'b0;
  endtask

  // request side: reset, directed table, random lines, end of run
  initial begin
    int         line_left;
    logic [7:0] c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(MODE_EXTRACT);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].md != cur_mode) begin
        settle();
        set_mode(DIR_ROWS[i].md);
      end
      offer_byte(DIR_ROWS[i].ch, DIR_ROWS[i].lst, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    // random lines, alternating modes; a line may run across a mode change
    line_left = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      set_mode((ph % 2) ? MODE_EXCLUDE : MODE_EXTRACT);
      no_idle = (ph == N_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;
        if (line_left == 0) line_left = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1:    c = $urandom_range(0, 1) ? CHAR_DQ : CHAR_SQ;
          2:       c = CHAR_BS;
          3: begin
            case ($urandom_range(0, 5))
              0:       c = ESC_N;
              1:       c = ESC_T;
              2:       c = ESC_B;
              3:       c = ESC_R;
              4:       c = ESC_F;
              default: c = ESC_V;
            endcase
          end
          4:       c = 8'($urandom_range(0, 255));
          default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        line_left--;
        offer_byte(c, line_left == 0, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // result side: random stall bursts, one long hold-off, none at the end
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: char %h valid %b end %b dropped %b line %b",
                   out_data_o.char_out, out_data_o.char_valid, out_data_o.string_end,
                   out_data_o.open_dropped, out_data_o.line_end);
      end else begin
        want = due_results.pop_front();
        if (out_data_o.char_out !== want.char_out || out_data_o.char_valid !== want.char_valid
            || out_data_o.string_end !== want.string_end
            || out_data_o.open_dropped !== want.open_dropped
            || out_data_o.line_end !== want.line_end) begin
          bad_count++;
          if (bad_count <= 10)
            $display({"mismatch: want char %h valid %b end %b dropped %b line %b,",
                      " got %h %b %b %b %b"},
                     want.char_out, want.char_valid, want.string_end, want.open_dropped,
                     want.line_end, out_data_o.char_out, out_data_o.char_valid,
                     out_data_o.string_end, out_data_o.open_dropped, out_data_o.line_end);
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
